@@ src/scvl_pkg.sv @@
// Shared constants for the soft current velocity limiter.
`timescale 1ns / 1ps
package scvl_pkg;

    localparam int SAMPLE_WIDTH = 16;

    localparam int SCALE_W    = 17;
    localparam int LIMIT_W    = 15;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP    = 2'd2;

    localparam logic [LIMIT_W-1:0] TRIP_LEVEL_RST = 15'd352;
    localparam logic [GAIN_W-1:0]  DOWN_GAIN_RST  = 16'd2621;
    localparam logic [SCALE_W-1:0] UP_STEP_RST    = 17'd655;

    // Stream packing
    localparam int IN_FIELDS_W  = 4 * SAMPLE_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * SAMPLE_WIDTH + 1 + 2 * SCALE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int OUT_LIMIT_BIT   = 2 * SAMPLE_WIDTH;
    localparam int OUT_LSCALE_LSB  = 2 * SAMPLE_WIDTH + 1;
    localparam int OUT_ASCALE_LSB  = OUT_LSCALE_LSB + SCALE_W;

    // Shared multiplier: excess or command by gain or scale
    localparam int MUL_A_W = SAMPLE_WIDTH + 1;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEC_W   = PROD_W - 8;
    localparam int CMP_W   = (SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W;

endpackage

@@ src/soft_current_velocity_limiter_core.sv @@
// Soft current velocity limiter: sequenced datapath around one shared multiplier.
`timescale 1ns / 1ps
// Usage:
//   Input beat on s_tvalid/s_tready/s_tdata carries one control tick: both wheel
//   currents and the commanded linear and angular velocity. Each accepted beat
//   yields exactly one result beat on m_tvalid/m_tready/m_tdata with the scaled
//   commands, the limiting flag and both updated Q1.16 scales.
//   Configuration registers (current threshold, down gain, up step) are written
//   through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write them only
//   while no tick is in flight. Unused indexes are dropped.
// Sequence:
//   Each tick runs through the seven sequencer steps: an idle/accept step, a
//   magnitude and compare step, then three passes through the single signed
//   multiplier (excess by gain, linear command by scale, angular command by
//   scale) with a scale update between the first and second. The result is
//   registered in the finish step once the output register is free, and s_tready
//   is high again from that same edge. A new tick is taken only back in idle.
// Reset (aresetn low, synchronous): both scales return to full scale, the
//   registers to their defaults, and no result is pending.
// Stall: a result waits in the output register; the next tick is still taken,
//   and its result holds in the last sequencer step until m_tready frees it.
module soft_current_velocity_limiter_core
    import scvl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // left_current, right_current, linear_cmd, angular_cmd
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // linear_out, angular_out, limiting, linear_scale_now, angular_scale_now
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW = SAMPLE_WIDTH;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PEAK    = 3'd1;
    localparam logic [2:0] ST_MUL_DEC = 3'd2;
    localparam logic [2:0] ST_UPDATE  = 3'd3;
    localparam logic [2:0] ST_MUL_LIN = 3'd4;
    localparam logic [2:0] ST_MUL_ANG = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    logic [2:0]             state_reg, state_next;

    logic [LIMIT_W-1:0]     trip_level_reg;
    logic [GAIN_W-1:0]      down_gain_reg;
    logic [SCALE_W-1:0]     up_step_reg;
    logic [SCALE_W-1:0]     lin_scale_reg, ang_scale_reg;

    logic signed [SW-1:0]   lc_reg, rc_reg, lin_reg, ang_reg;
    logic                   limiting_reg;
    logic [SW-1:0]          excess_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SW-1:0]          lin_res_reg;

    logic                   m_valid_reg;
    logic [SW-1:0]          lin_out_reg, ang_out_reg;
    logic                   limit_out_reg;
    logic [SCALE_W-1:0]     lscale_out_reg, ascale_out_reg;

    logic                   s_fire, out_free;

    // magnitude and compare
    logic signed [SW:0]     lc_ext, rc_ext, lc_neg, rc_neg;
    logic [SW-1:0]          lc_mag, rc_mag, peak;
    logic [CMP_W-1:0]       peak_cmp, limit_cmp, excess_full;
    logic                   over_limit;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // scale update
    logic [DEC_W-1:0]       dec;
    logic [SCALE_W:0]       lin_up, ang_up;
    logic [SCALE_W-1:0]     lin_rec, ang_rec;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_fire) state_next = ST_PEAK;
            ST_PEAK:    state_next = ST_MUL_DEC;
            ST_MUL_DEC: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_MUL_LIN;
            ST_MUL_LIN: state_next = ST_MUL_ANG;
            ST_MUL_ANG: state_next = ST_FINISH;
            ST_FINISH:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Most negative current takes its exact magnitude through the extra bit
    always_comb begin
        lc_ext   = {lc_reg[SW-1], lc_reg};
        rc_ext   = {rc_reg[SW-1], rc_reg};
        lc_neg   = -lc_ext;
        rc_neg   = -rc_ext;
        lc_mag   = lc_reg[SW-1] ? lc_neg[SW-1:0] : lc_reg;
        rc_mag   = rc_reg[SW-1] ? rc_neg[SW-1:0] : rc_reg;
        peak     = (lc_mag > rc_mag) ? lc_mag : rc_mag;
        peak_cmp  = CMP_W'(peak);
        limit_cmp = CMP_W'(trip_level_reg);
        over_limit  = peak_cmp > limit_cmp;
        excess_full = peak_cmp - limit_cmp;
    end

    always_comb begin
        case (state_reg)
            ST_MUL_DEC: begin
                mul_a = signed'({1'b0, excess_reg});
                mul_b = signed'(MUL_B_W'(down_gain_reg));
            end
            ST_MUL_LIN: begin
                mul_a = MUL_A_W'(lin_reg);
                mul_b = signed'({1'b0, lin_scale_reg});
            end
            default: begin
                mul_a = MUL_A_W'(ang_reg);
                mul_b = signed'({1'b0, ang_scale_reg});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        dec     = prod_reg[PROD_W-1:8];
        lin_up  = {1'b0, lin_scale_reg} + {1'b0, up_step_reg};
        ang_up  = {1'b0, ang_scale_reg} + {1'b0, up_step_reg};
        lin_rec = (lin_up > {1'b0, SCALE_ONE}) ? SCALE_ONE : lin_up[SCALE_W-1:0];
        ang_rec = (ang_up > {1'b0, SCALE_ONE}) ? SCALE_ONE : ang_up[SCALE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            trip_level_reg <= TRIP_LEVEL_RST;
            down_gain_reg  <= DOWN_GAIN_RST;
            up_step_reg    <= UP_STEP_RST;
            lin_scale_reg  <= SCALE_ONE;
            ang_scale_reg  <= SCALE_ONE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_index)
                    REG_TRIP_LEVEL: trip_level_reg <= cfg_data[LIMIT_W-1:0];
                    REG_DOWN_GAIN:  down_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_UP_STEP:    up_step_reg    <= cfg_data[SCALE_W-1:0];
                    default:        ;
                endcase
            end

            // Drain angular first; linear only once angular sits at zero
            if (state_reg == ST_UPDATE) begin
                if (limiting_reg) begin
                    if (ang_scale_reg != '0) begin
                        ang_scale_reg <= (dec >= DEC_W'(ang_scale_reg)) ? '0 :
                                         ang_scale_reg - dec[SCALE_W-1:0];
                    end else begin
                        lin_scale_reg <= (dec >= DEC_W'(lin_scale_reg)) ? '0 :
                                         lin_scale_reg - dec[SCALE_W-1:0];
                    end
                end else begin
                    lin_scale_reg <= lin_rec;
                    ang_scale_reg <= ang_rec;
                end
            end

            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lc_reg  <= s_tdata[SW-1:0];
            rc_reg  <= s_tdata[2*SW-1:SW];
            lin_reg <= s_tdata[3*SW-1:2*SW];
            ang_reg <= s_tdata[4*SW-1:3*SW];
        end
        if (state_reg == ST_PEAK) begin
            limiting_reg <= over_limit;
            excess_reg   <= excess_full[SW-1:0];
        end
        if (state_reg == ST_MUL_DEC || state_reg == ST_MUL_LIN ||
            state_reg == ST_MUL_ANG) begin
            prod_reg <= mul_p;
        end
        // Floor shift by 16 is the arithmetic shift of the product
        if (state_reg == ST_MUL_ANG) begin
            lin_res_reg <= prod_reg[SW+15:16];
        end
        if (state_reg == ST_FINISH && out_free) begin
            lin_out_reg    <= lin_res_reg;
            ang_out_reg    <= prod_reg[SW+15:16];
            limit_out_reg  <= limiting_reg;
            lscale_out_reg <= lin_scale_reg;
            ascale_out_reg <= ang_scale_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({ascale_out_reg, lscale_out_reg, limit_out_reg,
                                    ang_out_reg, lin_out_reg});

endmodule

@@ src/scvl_checker.sv @@
// Port-level checks for the soft current velocity limiter, bound to the top level.
`timescale 1ns / 1ps
module scvl_checker
    import scvl_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic [IN_TDATA_W-1:0]   s_tdata,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [OUT_TDATA_W-1:0]  m_tdata,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [CFG_IDX_W-1:0]    cfg_index,
    input logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [SCALE_W-1:0] lscale, ascale;

    assign lscale = m_tdata[OUT_LSCALE_LSB +: SCALE_W];
    assign ascale = m_tdata[OUT_ASCALE_LSB +: SCALE_W];

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // One tick in flight at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lscale <= SCALE_ONE) && (ascale <= SCALE_ONE))
        else $error("scale above full scale");

    // Angular drains first and both recover together, so it never leads linear
    a_scale_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ascale <= lscale)
        else $error("angular scale above linear scale");

endmodule

bind soft_current_velocity_limiter_core scvl_checker u_scvl_checker (.*);

@@ dv/scvl_limiter_checker.sv @@
// Scoreboard for the soft current velocity limiter: predicts every tick and checks result beats.
`timescale 1ns / 1ps
module scvl_limiter_checker
    import scvl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] linear_out;
        logic [SAMPLE_WIDTH-1:0] angular_out;
        logic                    limiting;
        logic [SCALE_W-1:0]      linear_scale;
        logic [SCALE_W-1:0]      angular_scale;
    } limiter_result_t;

    logic [LIMIT_W-1:0] thr_q;
    logic [GAIN_W-1:0]  gain_q;
    logic [SCALE_W-1:0] step_q;
    logic [SCALE_W-1:0] lin_scale_q;
    logic [SCALE_W-1:0] ang_scale_q;

    limiter_result_t pending_results[$];
    limiter_result_t want;
    int              result_idx;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
        fail_count++;
    endtask

    // floor(cmd * scale / 2^16), kept to the sample width
    function automatic logic [SAMPLE_WIDTH-1:0] scale_cmd(
        input logic signed [SAMPLE_WIDTH-1:0] cmd,
        input logic [SCALE_W-1:0]             scale
    );
        longint prod;
        prod = longint'(cmd) * longint'(scale);
        prod = prod >>> 16;
        return prod[SAMPLE_WIDTH-1:0];
    endfunction

    // Advance both scales by one tick and form the result beat it should produce
    function automatic limiter_result_t limit_tick(input logic [IN_TDATA_W-1:0] beat);
        logic signed [SAMPLE_WIDTH-1:0] left_i, right_i, lin_i, ang_i;
        int              mag_l, mag_r, peak, sum_a, sum_l;
        longint          drain;
        limiter_result_t r;
        left_i  = beat[0 +: SAMPLE_WIDTH];
        right_i = beat[SAMPLE_WIDTH +: SAMPLE_WIDTH];
        lin_i   = beat[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        ang_i   = beat[3*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        mag_l = (left_i < 0) ? -int'(left_i) : int'(left_i);
        mag_r = (right_i < 0) ? -int'(right_i) : int'(right_i);
        peak  = (mag_l > mag_r) ? mag_l : mag_r;
        r.limiting = (peak > int'(thr_q));
        if (r.limiting) begin
            drain = (longint'(peak - int'(thr_q)) * longint'(gain_q)) >>> 8;
            // angular gives way first; linear only once angular is already empty
            if (ang_scale_q != '0) begin
                if (drain >= longint'(ang_scale_q)) ang_scale_q = '0;
                else ang_scale_q = ang_scale_q - drain[SCALE_W-1:0];
            end else begin
                if (drain >= longint'(lin_scale_q)) lin_scale_q = '0;
                else lin_scale_q = lin_scale_q - drain[SCALE_W-1:0];
            end
        end else begin
            sum_a = int'(ang_scale_q) + int'(step_q);
            sum_l = int'(lin_scale_q) + int'(step_q);
            ang_scale_q = (sum_a > int'(SCALE_ONE)) ? SCALE_ONE : sum_a[SCALE_W-1:0];
            lin_scale_q = (sum_l > int'(SCALE_ONE)) ? SCALE_ONE : sum_l[SCALE_W-1:0];
        end
        r.linear_out    = scale_cmd(lin_i, lin_scale_q);
        r.angular_out   = scale_cmd(ang_i, ang_scale_q);
        r.linear_scale  = lin_scale_q;
        r.angular_scale = ang_scale_q;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_q       = TRIP_LEVEL_RST;
            gain_q      = DOWN_GAIN_RST;
            step_q      = UP_STEP_RST;
            lin_scale_q = SCALE_ONE;
            ang_scale_q = SCALE_ONE;
            pending_results.delete();
            outstanding = 0;
            fail_count  = 0;
            result_idx  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no tick waiting");
                end else begin
                    want = pending_results.pop_front();
                    outstanding--;
                    if (m_tdata[0 +: SAMPLE_WIDTH] !== want.linear_out)
                        report_mismatch($sformatf("linear_out got %0d, expected %0d",
                            $signed(m_tdata[0 +: SAMPLE_WIDTH]), $signed(want.linear_out)));
                    if (m_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH] !== want.angular_out)
                        report_mismatch($sformatf("angular_out got %0d, expected %0d",
                            $signed(m_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH]),
                            $signed(want.angular_out)));
                    if (m_tdata[OUT_LIMIT_BIT] !== want.limiting)
                        report_mismatch($sformatf("limiting got %b, expected %b",
                            m_tdata[OUT_LIMIT_BIT], want.limiting));
                    if (m_tdata[OUT_LSCALE_LSB +: SCALE_W] !== want.linear_scale)
                        report_mismatch($sformatf("linear_scale_now got %0d, expected %0d",
                            m_tdata[OUT_LSCALE_LSB +: SCALE_W], want.linear_scale));
                    if (m_tdata[OUT_ASCALE_LSB +: SCALE_W] !== want.angular_scale)
                        report_mismatch($sformatf("angular_scale_now got %0d, expected %0d",
                            m_tdata[OUT_ASCALE_LSB +: SCALE_W], want.angular_scale));
                end
                result_idx++;
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(limit_tick(s_tdata));
                outstanding++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TRIP_LEVEL: thr_q  = cfg_data[LIMIT_W-1:0];
                    REG_DOWN_GAIN:  gain_q = cfg_data[GAIN_W-1:0];
                    REG_UP_STEP:    step_q = cfg_data[SCALE_W-1:0];
                    default: ;  // drop writes to unused indexes
                endcase
            end
        end
    end

endmodule

@@ dv/tb_soft_current_velocity_limiter_core.sv @@
// Testbench top for the soft current velocity limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_soft_current_velocity_limiter_core;
    import scvl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SEGMENTS      = 5;
    localparam int SEGMENT_TICKS = 94;
    localparam int FULL_MAG      = 2 ** (SAMPLE_WIDTH - 1);

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count  = 0;
    int src_idle_pct = 6;
    int dst_idle_pct = 46;
    int cur_limit    = int'(TRIP_LEVEL_RST);

    soft_current_velocity_limiter_core uut (.*);

    scvl_limiter_checker u_limiter_check (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL soft_current_velocity_limiter_core");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_tick(
        input logic [SAMPLE_WIDTH-1:0] left_c,
        input logic [SAMPLE_WIDTH-1:0] right_c,
        input logic [SAMPLE_WIDTH-1:0] lin_c,
        input logic [SAMPLE_WIDTH-1:0] ang_c
    );
        return {ang_c, lin_c, right_c, left_c};
    endfunction

    // Most negative value is the only way to reach the full magnitude
    function automatic logic [SAMPLE_WIDTH-1:0] to_current(input int mag_val);
        int v;
        v = (mag_val >= FULL_MAG || $urandom_range(1) == 1) ? -mag_val : mag_val;
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [IN_TDATA_W-1:0] gen_beat(input bit over);
        int                      peak, other;
        logic [SAMPLE_WIDTH-1:0] a, b, lin_c, ang_c;
        lin_c = SAMPLE_WIDTH'($urandom);
        ang_c = SAMPLE_WIDTH'($urandom);
        if ($urandom_range(4) == 0) return {$urandom, $urandom};
        if (over) begin
            peak = cur_limit + 1
                 + (($urandom_range(3) == 0) ? $urandom_range(FULL_MAG) : $urandom_range(64));
            if (peak > FULL_MAG) peak = FULL_MAG;
        end else begin
            peak = $urandom_range(cur_limit);
        end
        other = $urandom_range(peak);
        a = to_current(peak);
        b = to_current(other);
        if ($urandom_range(1) == 1) return pack_tick(a, b, lin_c, ang_c);
        return pack_tick(b, a, lin_c, ang_c);
    endfunction

    // Enter and leave on a rising edge; valid stays high into the next beat unless it idles
    task automatic push_tick(input logic [IN_TDATA_W-1:0] beat);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every expected result beat has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(
        input logic [CFG_DATA_W-1:0] raw_limit,
        input logic [CFG_DATA_W-1:0] raw_gain,
        input logic [CFG_DATA_W-1:0] raw_step
    );
        drain_results();
        write_reg(REG_TRIP_LEVEL, raw_limit);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_DOWN_GAIN, raw_gain);
        write_reg(REG_UP_STEP, raw_step);
        cfg_valid <= 1'b0;
        cur_limit = int'(raw_limit[LIMIT_W-1:0]);
    endtask

    // Upper bits stay random so over-wide writes get truncated
    task automatic apply_random_settings();
        logic [CFG_DATA_W-1:0] lim, gain, step_v;
        lim    = CFG_DATA_W'($urandom);
        gain   = CFG_DATA_W'($urandom);
        step_v = CFG_DATA_W'($urandom);
        case ($urandom_range(3))
            0: lim[LIMIT_W-1:0] = '0;
            1: lim[LIMIT_W-1:0] = '1;
            2: lim[LIMIT_W-1:0] = LIMIT_W'($urandom_range(2000));
            default: ;
        endcase
        case ($urandom_range(5))
            0: gain[GAIN_W-1:0] = '0;
            1: gain[GAIN_W-1:0] = 1;
            2: gain[GAIN_W-1:0] = '1;
            3: gain[GAIN_W-1:0] = GAIN_W'($urandom_range(255));
            4: gain[GAIN_W-1:0] = GAIN_W'($urandom_range(4000));
            default: ;
        endcase
        case ($urandom_range(4))
            0: step_v = '0;
            1: step_v = SCALE_ONE;
            2: step_v = '1;
            3: step_v = CFG_DATA_W'($urandom_range(2000));
            default: ;
        endcase
        apply_settings(lim, gain, step_v);
    endtask

    // Runs of over-limit ticks drain the scales, runs under the limit let them recover
    task automatic run_segment(input int n);
        int sent;
        int run_len;
        bit over;
        sent = 0;
        while (sent < n) begin
            over    = $urandom_range(1);
            run_len = $urandom_range(1, 24);
            for (int k = 0; k < run_len && sent < n; k++) begin
                if (sent == n / 2) drain_results();
                push_tick(gen_beat(over));
                sent++;
            end
        end
    endtask

    task automatic run_directed();
        // reset register values
        push_tick(pack_tick(0, 0, 32767, -32768));
        push_tick(pack_tick(352, -352, -1, 1));
        push_tick(pack_tick(353, 0, 32767, 32767));
        push_tick(pack_tick(0, -353, -32768, -32768));
        push_tick(pack_tick(-32768, 0, -32768, 32767));
        push_tick(pack_tick(0, -32768, 12345, -12345));
        push_tick(pack_tick(32767, -32768, 32767, -32768));
        repeat (3) push_tick(pack_tick(0, 0, -32768, 32767));
        push_tick(pack_tick(-353, 100, -7, 7));
        // zero threshold, unit gain: small excess gives a zero decrement
        apply_settings(17'd0, 17'd1, SCALE_ONE);
        push_tick(pack_tick(0, 0, -32768, -1));
        push_tick(pack_tick(1, 0, 100, -100));
        push_tick(pack_tick(-1, -1, -3, 3));
        push_tick(pack_tick(0, -300, 5, 5));
        push_tick(pack_tick(0, 0, 1, -1));
        // all ones on every register: widest threshold, gain and step
        apply_settings('1, '1, '1);
        push_tick(pack_tick(-32768, 32767, 32767, -32768));
        push_tick(pack_tick(32767, -32767, -32768, 32767));
        push_tick(pack_tick(-32768, -32768, 0, 0));
        push_tick(pack_tick(0, 0, 32767, 32767));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 46 : 0;
            dst_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 6 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                apply_random_settings();
                run_segment(SEGMENT_TICKS);
            end
        end
        drain_results();
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS soft_current_velocity_limiter_core");
        end else begin
            $display("FAIL soft_current_velocity_limiter_core");
        end
        $finish;
    end

endmodule
